/* hw/rtl/kdb_pkg.sv */
package kdb_pkg;

  // build constants
  localparam int NumKeys   = 8;
  localparam int StampBits = 32;
  localparam int LevelBits = 8;
  localparam int NumLanes  = (NumKeys < LevelBits) ? NumKeys : LevelBits;

  // field widths
  localparam int NowBits     = 32;
  localparam int DebBits     = 16;
  localparam int LaneCntBits = 4;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;

  // register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DEBOUNCE_MS  = 2'd0,
    CFG_CONTINUOUS   = 2'd1,
    CFG_KEYS_IN_USE  = 2'd2
  } cfg_idx_t;

  // register reset values
  localparam logic [DebBits-1:0]     DebounceReset = 16'd50;
  localparam logic                   ContReset     = 1'b0;
  localparam logic [LaneCntBits-1:0] KeysReset     = 4'd8;

  typedef logic [StampBits-1:0] stamp_t;

endpackage

/* hw/rtl/kdb_ifs.sv */
interface kdb_scan_if;
  import kdb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LevelBits-1:0] key_levels;
  logic [NowBits-1:0]   now_ms;

  modport source (output valid, output key_levels, output now_ms, input ready);
  modport sink (input valid, input key_levels, input now_ms, output ready);
endinterface

interface kdb_mask_if;
  import kdb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LevelBits-1:0] pressed_mask;

  modport source (output valid, output pressed_mask, input ready);
  modport sink (input valid, input pressed_mask, output ready);
endinterface

/* hw/rtl/keypad_debounce_scan.sv */
// result: pressed_mask is registered and valid in the cycle after each scan transfer
// throughput: one scan per cycle while the mask side takes each result
// the output register stalls the scan side only when a held mask is not taken
// reset: all lanes unlatched with zero stamps, output empty,
// debounce 50 ms, single mode, eight lanes scanned
module keypad_debounce_scan
  import kdb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  kdb_scan_if.sink               scan,
  kdb_mask_if.source             mask,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data
);

  // configuration registers
  logic [DebBits-1:0]     debounce_ms;
  logic                   continuous_mode;
  logic [LaneCntBits-1:0] keys_in_use;

  // lane state
  logic   [NumLanes-1:0] latched;
  stamp_t                stamp [NumLanes];

  logic   [NumLanes-1:0] latched_next;
  stamp_t                stamp_next [NumLanes];
  logic [LevelBits-1:0]  mask_next;
  logic [LaneCntBits-1:0] lanes;
  stamp_t                now;
  logic                  accept;

  logic                  out_valid;
  logic [LevelBits-1:0]  out_mask;

  assign scan.ready        = !out_valid || mask.ready;
  assign accept            = scan.valid && scan.ready;
  assign mask.valid        = out_valid;
  assign mask.pressed_mask = out_mask;

  assign now   = StampBits'(scan.now_ms);
  assign lanes = (keys_in_use > LaneCntBits'(NumLanes)) ? LaneCntBits'(NumLanes)
                                                        : keys_in_use;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DebounceReset;
      continuous_mode <= ContReset;
      keys_in_use     <= KeysReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_ms     <= DebBits'(cfg_data);
        CFG_CONTINUOUS:  continuous_mode <= cfg_data[0];
        CFG_KEYS_IN_USE: keys_in_use     <= LaneCntBits'(cfg_data);
        default: ;
      endcase
    end
  end

  // per-lane debounce, all lanes in parallel
  always_comb begin
    mask_next = '0;
    for (int i = 0; i < NumLanes; i++) begin
      logic   low;
      logic   fire;
      stamp_t elapsed;
      low             = !scan.key_levels[i];
      elapsed         = now - stamp[i];
      fire            = low && !latched[i] && (elapsed > StampBits'(debounce_ms));
      latched_next[i] = latched[i];
      stamp_next[i]   = stamp[i];
      if (LaneCntBits'(i) < lanes) begin
        if (!low) begin
          latched_next[i] = 1'b0;
          stamp_next[i]   = now;
        end else if (fire) begin
          latched_next[i] = 1'b1;
          stamp_next[i]   = now;
        end
        mask_next[i] = continuous_mode ? (low && latched_next[i]) : fire;
      end
    end
  end

  // lane state update on each scan transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      latched <= '0;
      for (int i = 0; i < NumLanes; i++) begin
        stamp[i] <= '0;
      end
    end else if (accept) begin
      latched <= latched_next;
      for (int i = 0; i < NumLanes; i++) begin
        stamp[i] <= stamp_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (mask.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mask <= mask_next;
    end
  end

endmodule

/* hw/rtl/kdb_checker.sv */
module kdb_checker
  import kdb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 scan_valid,
  input logic                 scan_ready,
  input logic                 mask_valid,
  input logic                 mask_ready,
  input logic [LevelBits-1:0] pressed_mask
);

  // output is empty straight after reset
  assert property (@(posedge clk) rst |=> !mask_valid)
    else $error("mask valid after reset");

  // every scan transfer yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    scan_valid && scan_ready |=> mask_valid)
    else $error("scan transfer without result");

  // no result appears without a scan transfer
  assert property (@(posedge clk) disable iff (rst)
    !(scan_valid && scan_ready) && !(mask_valid && !mask_ready) |=> !mask_valid)
    else $error("result without scan transfer");

  // a stalled result blocks the scan side
  assert property (@(posedge clk) disable iff (rst)
    mask_valid && !mask_ready |-> !scan_ready)
    else $error("scan taken while result stalled");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    mask_valid && !mask_ready |=> mask_valid && $stable(pressed_mask))
    else $error("stalled result changed");

endmodule

bind keypad_debounce_scan kdb_checker u_kdb_checker (
  .clk          (clk),
  .rst          (rst),
  .scan_valid   (scan.valid),
  .scan_ready   (scan.ready),
  .mask_valid   (mask.valid),
  .mask_ready   (mask.ready),
  .pressed_mask (mask.pressed_mask)
);
